// ===== sv/vspr_pkg.sv =====
// Shared types and constants for the virtual subnet peer router.
// Used by the router top level and its port checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package vspr_pkg;

   localparam int PEER_SLOTS_DEF = 16;
   localparam int MAX_RESULTS    = 16;

   localparam int CMD_W       = 3;
   localparam int KIND_W      = 3;
   localparam int CONN_W      = 32;
   localparam int LEN_W       = 16;
   localparam int VER_W       = 4;
   localparam int OCT_W       = 8;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 40;

   localparam logic [LEN_W-1:0] IPV4_MIN_LEN   = 16'd20;
   localparam logic [VER_W-1:0] IPV4_VERSION   = 4'd4;
   localparam logic [OCT_W-1:0] MCAST_FIRST_LO = 8'd224;
   localparam logic [OCT_W-1:0] MCAST_FIRST_HI = 8'd239;

   localparam logic [OCT_W-1:0] MIN_PEER_OCTET_RST  = 8'd2;
   localparam logic [OCT_W-1:0] MAX_PEER_OCTET_RST  = 8'd254;
   localparam logic [OCT_W-1:0] HOST_OCTET_RST      = 8'd1;
   localparam logic [OCT_W-1:0] BROADCAST_OCTET_RST = 8'd255;

   typedef enum logic [CMD_W-1:0] {
      CMD_CONNECT_REQ = 3'd0,
      CMD_CONNECTED   = 3'd1,
      CMD_CLOSED      = 3'd2,
      CMD_LOCAL_PKT   = 3'd3,
      CMD_PEER_PKT    = 3'd4
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPT   = 3'd0,
      KIND_REFUSE   = 3'd1,
      KIND_ASSIGNED = 3'd2,
      KIND_LOCAL    = 3'd3,
      KIND_PEER     = 3'd4
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MIN_PEER_OCTET  = 2'd0,
      CSR_MAX_PEER_OCTET  = 2'd1,
      CSR_HOST_OCTET      = 2'd2,
      CSR_BROADCAST_OCTET = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_READ,
      S_EVAL,
      S_PICK,
      S_FLUSH
   } state_type;

endpackage

`default_nettype wire

// ===== sv/virtual_subnet_peer_router_unit.sv =====
// Top level of the virtual subnet peer router: peer table memories, sequencer and result path.
// Depends on vspr_pkg for types, widths and reset values.
//
// Usage: commands and packet headers enter on the req_ stream, one beat per item, with the
// command in req_tuser. Results leave on the rsp_ stream with the result kind in rsp_tuser and
// tlast on the final result of an item; closed events and unknown commands give no beat.
// The csr_ port writes the four octet registers; the user must write them only while the block
// is idle, which the block itself does not enforce. The peer table lives in two synchronous
// memories with registered reads. An item is taken only while the sequencer is idle. A connect
// request, or a packet that needs no table search, places any result in the holding register
// at dispatch and then flushes it. Connected events, closed events and packets routed to peers
// walk the table, reading and then evaluating each entry; a unicast route stops at the first
// matching peer, and a connected event then picks the octet. One finished result waits in a
// holding register so that tlast can be set, and one more sits in the output register; when
// the receiver stalls, the walk pauses at the next result until the output register drains.
// The flush state passes the held result on before the next item is taken.
// Reset empties the table, restores the register defaults and drops any result in flight.
`timescale 1ns / 1ps
`default_nettype none

module virtual_subnet_peer_router_unit #(
   parameter int PEER_SLOTS = vspr_pkg::PEER_SLOTS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // conn_id, pkt_len, ip_version, dest_first_octet, dest_last_octet, zero padding
   input  wire  [vspr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // cmd
   input  wire  [vspr_pkg::CMD_W-1:0]           req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // target_conn, octet
   output logic [vspr_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // kind
   output logic [vspr_pkg::KIND_W-1:0]          rsp_tuser,
   output logic                                 rsp_tlast,
   input  wire                                  csr_we,
   input  wire  [vspr_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire  [vspr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CNT_W = $clog2(PEER_SLOTS + 1);
   localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int RES_W = $clog2(vspr_pkg::MAX_RESULTS + 1);
   localparam int CW    = vspr_pkg::CONN_W;
   localparam int OW    = vspr_pkg::OCT_W;
   localparam int KW    = vspr_pkg::KIND_W;

   logic [CW-1:0] conn_mem [PEER_SLOTS];
   logic [OW-1:0] oct_mem  [PEER_SLOTS];

   vspr_pkg::state_type state_ff, state_in;

   logic [OW-1:0] min_oct_ff, max_oct_ff, host_oct_ff, bc_oct_ff;

   logic [vspr_pkg::CMD_W-1:0] cmd_ff;
   logic [CW-1:0]              conn_ff;
   logic                       ipv4_ff, mcast_ff;
   logic [OW-1:0]              lastb_ff;

   logic [OW-1:0]       dest_ff, dest_in;
   logic                bcast_ff, bcast_in;
   logic                skip_ff, skip_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    keep_ff, keep_in;
   logic [PEER_SLOTS:0] used_ff, used_in;
   logic [RES_W-1:0]    nres_ff;

   logic          pend_valid_ff;
   logic [KW-1:0] pend_kind_ff;
   logic [CW-1:0] pend_conn_ff;
   logic [OW-1:0] pend_oct_ff;

   logic          rsp_valid_ff, rsp_last_ff;
   logic [KW-1:0] rsp_kind_ff;
   logic [CW-1:0] rsp_conn_ff;
   logic [OW-1:0] rsp_oct_ff;

   logic [CW-1:0] rd_conn_ff;
   logic [OW-1:0] rd_oct_ff;

   logic             req_fire;
   logic             gen_want, gen_stall, gen_push, cap_hit, out_free, flush_go;
   logic [KW-1:0]    gen_kind;
   logic [CW-1:0]    gen_conn;
   logic [OW-1:0]    gen_oct;
   logic             rd_en, wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [CW-1:0]    wr_conn;
   logic [OW-1:0]    wr_oct;
   logic             range_full, hit, last_entry, in_window;
   logic [8:0]       range_size;
   logic [OW-1:0]    oct_diff;
   logic [CNT_W-1:0] pick_d;
   logic [8:0]       pick_sum;
   logic             pick_ok;
   logic [OW-1:0]    loc_dest;
   logic             loc_bcast, peer_bcast;
   logic             req_ipv4, req_mcast;

   assign req_tready = (state_ff == vspr_pkg::S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign req_ipv4  = (req_tdata[47:32] >= vspr_pkg::IPV4_MIN_LEN) &&
                      (req_tdata[51:48] == vspr_pkg::IPV4_VERSION);
   assign req_mcast = req_ipv4 && (req_tdata[59:52] >= vspr_pkg::MCAST_FIRST_LO) &&
                      (req_tdata[59:52] <= vspr_pkg::MCAST_FIRST_HI);

   assign range_size = {1'b0, max_oct_ff} - {1'b0, min_oct_ff} + 9'd1;
   assign range_full = (count_ff >= CNT_W'(PEER_SLOTS)) || (max_oct_ff < min_oct_ff) ||
                       (9'(count_ff) >= range_size);

   assign loc_dest   = ipv4_ff ? lastb_ff : bc_oct_ff;
   assign loc_bcast  = !ipv4_ff || mcast_ff || (loc_dest == bc_oct_ff);
   assign peer_bcast = mcast_ff || (lastb_ff == bc_oct_ff);

   assign hit = !(skip_ff && (rd_conn_ff == conn_ff)) && (bcast_ff || (rd_oct_ff == dest_ff));
   assign last_entry = ((idx_ff + 1'b1) == count_ff);

   assign oct_diff  = rd_oct_ff - min_oct_ff;
   assign in_window = (rd_oct_ff >= min_oct_ff) && (oct_diff <= OW'(PEER_SLOTS));

   always_comb begin
      pick_d = '0;
      for (int i = PEER_SLOTS; i >= 0; i--) begin
         if (!used_ff[i]) begin
            pick_d = CNT_W'(i);
         end
      end
   end

   assign pick_sum = {1'b0, min_oct_ff} + 9'(pick_d);
   assign pick_ok  = (pick_sum <= {1'b0, max_oct_ff});

   always_comb begin
      gen_want = 1'b0;
      gen_kind = vspr_pkg::KIND_ACCEPT;
      gen_conn = conn_ff;
      gen_oct  = '0;
      case (state_ff)
         vspr_pkg::S_DISPATCH: begin
            case (cmd_ff)
               vspr_pkg::CMD_CONNECT_REQ: begin
                  gen_want = 1'b1;
                  gen_kind = range_full ? vspr_pkg::KIND_REFUSE : vspr_pkg::KIND_ACCEPT;
               end
               vspr_pkg::CMD_CONNECTED: begin
                  if (count_ff == CNT_W'(PEER_SLOTS)) begin
                     gen_want = 1'b1;
                     gen_kind = vspr_pkg::KIND_REFUSE;
                  end
               end
               vspr_pkg::CMD_PEER_PKT: begin
                  gen_conn = '0;
                  if (!ipv4_ff) begin
                     gen_want = 1'b1;
                     gen_kind = vspr_pkg::KIND_LOCAL;
                  end else if ((lastb_ff == host_oct_ff) || peer_bcast) begin
                     gen_want = 1'b1;
                     gen_kind = vspr_pkg::KIND_LOCAL;
                     gen_oct  = lastb_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         vspr_pkg::S_EVAL: begin
            if ((cmd_ff == vspr_pkg::CMD_LOCAL_PKT || cmd_ff == vspr_pkg::CMD_PEER_PKT) && hit) begin
               gen_want = 1'b1;
               gen_kind = vspr_pkg::KIND_PEER;
               gen_conn = rd_conn_ff;
               gen_oct  = dest_ff;
            end
         end
         vspr_pkg::S_PICK: begin
            gen_want = 1'b1;
            gen_kind = pick_ok ? vspr_pkg::KIND_ASSIGNED : vspr_pkg::KIND_REFUSE;
            gen_oct  = pick_ok ? pick_sum[OW-1:0] : '0;
         end
         default: begin
         end
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign cap_hit   = (nres_ff == RES_W'(vspr_pkg::MAX_RESULTS));
   assign gen_stall = gen_want && !cap_hit && pend_valid_ff && !out_free;
   assign gen_push  = gen_want && !cap_hit && !gen_stall;

   always_comb begin
      state_in = state_ff;
      dest_in  = dest_ff;
      bcast_in = bcast_ff;
      skip_in  = skip_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      keep_in  = keep_ff;
      used_in  = used_ff;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = keep_ff[IDX_W-1:0];
      wr_conn  = rd_conn_ff;
      wr_oct   = rd_oct_ff;
      flush_go = 1'b0;
      case (state_ff)
         vspr_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = vspr_pkg::S_DISPATCH;
            end
         end
         vspr_pkg::S_DISPATCH: begin
            idx_in  = '0;
            keep_in = '0;
            used_in = '0;
            if (!gen_stall) begin
               case (cmd_ff)
                  vspr_pkg::CMD_CONNECT_REQ: begin
                     state_in = vspr_pkg::S_FLUSH;
                  end
                  vspr_pkg::CMD_CONNECTED: begin
                     if (count_ff == CNT_W'(PEER_SLOTS)) begin
                        state_in = vspr_pkg::S_FLUSH;
                     end else if (count_ff == '0) begin
                        state_in = vspr_pkg::S_PICK;
                     end else begin
                        state_in = vspr_pkg::S_READ;
                     end
                  end
                  vspr_pkg::CMD_CLOSED: begin
                     state_in = (count_ff == '0) ? vspr_pkg::S_IDLE : vspr_pkg::S_READ;
                  end
                  vspr_pkg::CMD_LOCAL_PKT: begin
                     dest_in  = loc_dest;
                     bcast_in = loc_bcast;
                     skip_in  = 1'b0;
                     state_in = (count_ff == '0) ? vspr_pkg::S_FLUSH : vspr_pkg::S_READ;
                  end
                  vspr_pkg::CMD_PEER_PKT: begin
                     dest_in  = lastb_ff;
                     bcast_in = peer_bcast;
                     skip_in  = 1'b1;
                     if (ipv4_ff && ((lastb_ff != host_oct_ff) || peer_bcast) &&
                         (count_ff != '0)) begin
                        state_in = vspr_pkg::S_READ;
                     end else begin
                        state_in = vspr_pkg::S_FLUSH;
                     end
                  end
                  default: begin
                     state_in = vspr_pkg::S_IDLE;
                  end
               endcase
            end
         end
         vspr_pkg::S_READ: begin
            rd_en    = 1'b1;
            state_in = vspr_pkg::S_EVAL;
         end
         vspr_pkg::S_EVAL: begin
            if (!gen_stall) begin
               idx_in = idx_ff + 1'b1;
               case (cmd_ff)
                  vspr_pkg::CMD_CONNECTED: begin
                     if (in_window) begin
                        used_in[oct_diff[CNT_W-1:0]] = 1'b1;
                     end
                     state_in = last_entry ? vspr_pkg::S_PICK : vspr_pkg::S_READ;
                  end
                  vspr_pkg::CMD_CLOSED: begin
                     if (rd_conn_ff != conn_ff) begin
                        wr_en   = 1'b1;
                        keep_in = keep_ff + 1'b1;
                     end
                     if (last_entry) begin
                        count_in = keep_in;
                        state_in = vspr_pkg::S_IDLE;
                     end else begin
                        state_in = vspr_pkg::S_READ;
                     end
                  end
                  default: begin
                     if (last_entry || (hit && !bcast_ff)) begin
                        state_in = vspr_pkg::S_FLUSH;
                     end else begin
                        state_in = vspr_pkg::S_READ;
                     end
                  end
               endcase
            end
         end
         vspr_pkg::S_PICK: begin
            wr_addr = count_ff[IDX_W-1:0];
            wr_conn = conn_ff;
            wr_oct  = pick_sum[OW-1:0];
            if (!gen_stall) begin
               if (pick_ok) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               state_in = vspr_pkg::S_FLUSH;
            end
         end
         vspr_pkg::S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = vspr_pkg::S_IDLE;
            end else if (out_free) begin
               flush_go = 1'b1;
               state_in = vspr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = vspr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vspr_pkg::S_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         keep_ff  <= '0;
         used_ff  <= '0;
         dest_ff  <= '0;
         bcast_ff <= 1'b0;
         skip_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         keep_ff  <= keep_in;
         used_ff  <= used_in;
         dest_ff  <= dest_in;
         bcast_ff <= bcast_in;
         skip_ff  <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_oct_ff  <= vspr_pkg::MIN_PEER_OCTET_RST;
         max_oct_ff  <= vspr_pkg::MAX_PEER_OCTET_RST;
         host_oct_ff <= vspr_pkg::HOST_OCTET_RST;
         bc_oct_ff   <= vspr_pkg::BROADCAST_OCTET_RST;
      end else if (csr_we) begin
         case (csr_addr)
            vspr_pkg::CSR_MIN_PEER_OCTET:  min_oct_ff  <= csr_wdata;
            vspr_pkg::CSR_MAX_PEER_OCTET:  max_oct_ff  <= csr_wdata;
            vspr_pkg::CSR_HOST_OCTET:      host_oct_ff <= csr_wdata;
            vspr_pkg::CSR_BROADCAST_OCTET: bc_oct_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req_tuser;
         conn_ff  <= req_tdata[31:0];
         ipv4_ff  <= req_ipv4;
         mcast_ff <= req_mcast;
         lastb_ff <= req_tdata[67:60];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         conn_mem[wr_addr] <= wr_conn;
         oct_mem[wr_addr]  <= wr_oct;
      end
      if (rd_en) begin
         rd_conn_ff <= conn_mem[idx_ff[IDX_W-1:0]];
         rd_oct_ff  <= oct_mem[idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         nres_ff       <= '0;
      end else begin
         if (req_fire) begin
            nres_ff <= '0;
         end else if (gen_push) begin
            nres_ff <= nres_ff + 1'b1;
         end
         if (gen_push) begin
            pend_valid_ff <= 1'b1;
         end else if (flush_go) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (gen_push) begin
         pend_kind_ff <= gen_kind;
         pend_conn_ff <= gen_conn;
         pend_oct_ff  <= gen_oct;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((gen_push && pend_valid_ff) || flush_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((gen_push && pend_valid_ff) || flush_go) begin
         rsp_kind_ff <= pend_kind_ff;
         rsp_conn_ff <= pend_conn_ff;
         rsp_oct_ff  <= pend_oct_ff;
         rsp_last_ff <= flush_go;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_oct_ff, rsp_conn_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== sv/vspr_checker.sv =====
// Port checker for the virtual subnet peer router, bound to the top level.
// Depends on vspr_pkg for widths and result kinds.
`timescale 1ns / 1ps
`default_nettype none

module vspr_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [vspr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire [vspr_pkg::KIND_W-1:0]       rsp_tuser,
   input wire                              rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   a_rsp_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat straight after reset");

   a_local_target: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == vspr_pkg::KIND_LOCAL) |-> (rsp_tdata[31:0] == '0))
      else $error("local adapter beat names a connection");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == vspr_pkg::KIND_ACCEPT) ||
                     (rsp_tuser == vspr_pkg::KIND_REFUSE) ||
                     (rsp_tuser == vspr_pkg::KIND_ASSIGNED)) |-> rsp_tlast)
      else $error("connection event beat without tlast");

endmodule

bind virtual_subnet_peer_router_unit vspr_checker u_vspr_checker (.*);

`default_nettype wire
